FILE: rtl/pmvp_pkg.sv
package pmvp_pkg;

    // Palette store geometry
    localparam int PALETTE_DEPTH = 1024;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int RGB_W         = 24;
    localparam int SIZE_W        = 11;
    localparam int SCALE_W       = 31;
    localparam int DIFF_W        = 10;

    // Shared divider: numerator holds |distance| * 2047 or 255 * sum, divisor a world scale or psum + 1
    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = SCALE_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [10:0] CODE_MAX = 11'd2047;
    localparam logic [7:0]  MOD_MAX  = 8'd255;

    // Input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_PALETTE_SIZE = 1'b0;
    localparam logic CFG_WORLD_SCALE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/pmvp_ram.sv
module pmvp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pmvp_div.sv
module pmvp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pmvp_pkg::div_req_t req,
    output pmvp_pkg::div_rsp_t rsp
);
    import pmvp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DEN_W:0]   rem_sub;

    // One restoring step per cycle, MSB of the numerator first
    assign rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[DIV_NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_NUM_W-2:0], ge};
            rem_next  = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: rtl/palette_match_voxel_pack.sv
// Nearest palette color search with voxel packing. A write transaction
// (cmd 0) stores one RGB entry in a 1024 x 24 single-port palette RAM;
// it gives no result. A query transaction (cmd 1) scans entries
// 0 .. palette_size-1 (entry 0 alone for size zero, at most 1023), one
// RAM read per cycle, keeps the first entry with the least L1 RGB
// distance, then runs two 42-step radix-2 divides on one shared divider:
// the brightness ratio 255*sum/(psum+1) and the distance code
// 2047*|distance|/world_scale, both saturated. A query holds the input
// through the scan (one read port, registered read), the two serial
// divides and the output load, which waits for a free output register.
// The next item is taken once a query has moved into the output register,
// even while that result is stalled. Configuration must be written only
// while idle; the block does not enforce it. cfg_ready is always high.
module palette_match_voxel_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [pmvp_pkg::ADDR_W-1:0]   entry_index,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic signed [31:0]            distance,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pmvp_pkg::ADDR_W-1:0]   color_index,
    output logic [7:0]                    modifier,
    output logic signed [11:0]            distance_code,
    output logic [31:0]                   voxel_word,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [pmvp_pkg::SCALE_W-1:0]  cfg_data
);
    import pmvp_pkg::*;

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        abs_diff8 = (a > b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers
    logic [SIZE_W-1:0]  palette_size_reg;
    logic [SCALE_W-1:0] world_scale_reg;

    // Control
    state_t             state_reg, state_next;
    logic               issuing_reg, issuing_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath
    logic [ADDR_W-1:0]  scan_addr_reg, scan_addr_next;
    logic [ADDR_W-1:0]  scan_last_reg, scan_last_next;
    logic [ADDR_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]  best_idx_reg, best_idx_next;
    logic [DIFF_W-1:0]  best_diff_reg, best_diff_next;
    logic [RGB_W-1:0]   best_rgb_reg, best_rgb_next;
    logic [RGB_W-1:0]   q_rgb_reg, q_rgb_next;
    logic               dist_neg_reg, dist_neg_next;
    logic [31:0]        dist_mag_reg, dist_mag_next;
    logic [7:0]         mod_reg, mod_next;
    logic [11:0]        code_reg, code_next;
    logic [ADDR_W-1:0]  color_index_reg, color_index_next;
    logic [7:0]         modifier_reg, modifier_next;
    logic [11:0]        distance_code_reg, distance_code_next;

    logic               in_accept;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [RGB_W-1:0]   ram_rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [DIFF_W-1:0]  cand_diff;
    logic [ADDR_W-1:0]  last_idx;
    logic [31:0]        dist_u;
    logic [DIFF_W-1:0]  q_sum;
    logic [DIFF_W-1:0]  p_sum_inc;
    logic [17:0]        mod_num;
    logic [DIV_NUM_W:0] dist_num;
    logic [10:0]        code_mag;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Palette RAM: writes in idle, scan reads otherwise
    assign ram_we   = in_accept && (cmd == CMD_WRITE);
    assign ram_addr = ram_we ? entry_index : scan_addr_reg;

    pmvp_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({red, green, blue}),
        .rdata (ram_rdata)
    );

    pmvp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // L1 distance of the entry just read
    assign cand_diff = DIFF_W'(abs_diff8(ram_rdata[23:16], q_rgb_reg[23:16]))
                     + DIFF_W'(abs_diff8(ram_rdata[15:8],  q_rgb_reg[15:8]))
                     + DIFF_W'(abs_diff8(ram_rdata[7:0],   q_rgb_reg[7:0]));

    // Last entry to scan: zero size scans entry 0, oversize saturates
    always_comb
    begin
        if (palette_size_reg == '0)
        begin
            last_idx = '0;
        end
        else if (palette_size_reg >= SIZE_W'(PALETTE_DEPTH))
        begin
            last_idx = ADDR_W'(PALETTE_DEPTH - 1);
        end
        else
        begin
            last_idx = ADDR_W'(palette_size_reg - SIZE_W'(1));
        end
    end

    // Divider operands: x*255 and x*2047 as shift and subtract
    assign dist_u    = $unsigned(distance);
    assign q_sum     = DIFF_W'(q_rgb_reg[23:16]) + DIFF_W'(q_rgb_reg[15:8])
                     + DIFF_W'(q_rgb_reg[7:0]);
    assign p_sum_inc = DIFF_W'(best_rgb_reg[23:16]) + DIFF_W'(best_rgb_reg[15:8])
                     + DIFF_W'(best_rgb_reg[7:0]) + DIFF_W'(1);
    assign mod_num   = {q_sum, 8'd0} - 18'(q_sum);
    assign dist_num  = {dist_mag_reg, 11'd0} - (DIV_NUM_W + 1)'(dist_mag_reg);

    always_comb
    begin
        div_req.start = (state_reg == ST_MOD_GO) || (state_reg == ST_DIST_GO);
        if (state_reg == ST_DIST_GO)
        begin
            div_req.num = dist_num[DIV_NUM_W-1:0];
            div_req.den = world_scale_reg;
        end
        else
        begin
            div_req.num = DIV_NUM_W'(mod_num);
            div_req.den = DIV_DEN_W'(p_sum_inc);
        end
    end

    // Saturated distance magnitude; zero distance always codes zero
    always_comb
    begin
        if (dist_mag_reg == '0)
        begin
            code_mag = '0;
        end
        else if (div_rsp.quot[DIV_NUM_W-1:11] != '0)
        begin
            code_mag = CODE_MAX;
        end
        else
        begin
            code_mag = div_rsp.quot[10:0];
        end
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next         = state_reg;
        issuing_next       = issuing_reg;
        rd_pend_next       = 1'b0;
        rd_last_next       = 1'b0;
        rd_idx_next        = rd_idx_reg;
        scan_addr_next     = scan_addr_reg;
        scan_last_next     = scan_last_reg;
        best_idx_next      = best_idx_reg;
        best_diff_next     = best_diff_reg;
        best_rgb_next      = best_rgb_reg;
        q_rgb_next         = q_rgb_reg;
        dist_neg_next      = dist_neg_reg;
        dist_mag_next      = dist_mag_reg;
        mod_next           = mod_reg;
        code_next          = code_reg;
        out_valid_next     = out_valid_reg && out_stall;
        color_index_next   = color_index_reg;
        modifier_next      = modifier_reg;
        distance_code_next = distance_code_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (cmd == CMD_QUERY))
                begin
                    state_next     = ST_SCAN;
                    issuing_next   = 1'b1;
                    scan_addr_next = '0;
                    scan_last_next = last_idx;
                    best_idx_next  = '0;
                    best_diff_next = '1;
                    q_rgb_next     = {red, green, blue};
                    dist_neg_next  = dist_u[31];
                    dist_mag_next  = dist_u[31] ? (~dist_u + 32'd1) : dist_u;
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle
                if (issuing_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = scan_addr_reg;
                    rd_last_next = (scan_addr_reg == scan_last_reg);
                    if (scan_addr_reg == scan_last_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + ADDR_W'(1);
                    end
                end
                // compare the entry read last cycle; strict less keeps the first
                if (rd_pend_reg)
                begin
                    if (cand_diff < best_diff_reg)
                    begin
                        best_diff_next = cand_diff;
                        best_idx_next  = rd_idx_reg;
                        best_rgb_next  = ram_rdata;
                    end
                    if (rd_last_reg)
                    begin
                        state_next = ST_MOD_GO;
                    end
                end
            end
            ST_MOD_GO:
            begin
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mod_next   = (div_rsp.quot[DIV_NUM_W-1:8] != '0) ? MOD_MAX
                                                                    : div_rsp.quot[7:0];
                    state_next = ST_DIST_GO;
                end
            end
            ST_DIST_GO:
            begin
                state_next = ST_DIST_WAIT;
            end
            ST_DIST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    code_next  = dist_neg_reg ? (~{1'b0, code_mag} + 12'd1)
                                              : {1'b0, code_mag};
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    color_index_next   = best_idx_reg;
                    modifier_next      = mod_reg;
                    distance_code_next = code_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issuing_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issuing_reg   <= issuing_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg <= SIZE_W'(1);
            world_scale_reg  <= SCALE_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PALETTE_SIZE)
            begin
                palette_size_reg <= cfg_data[SIZE_W-1:0];
            end
            else if (cfg_index == CFG_WORLD_SCALE)
            begin
                world_scale_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg        <= rd_idx_next;
        scan_addr_reg     <= scan_addr_next;
        scan_last_reg     <= scan_last_next;
        best_idx_reg      <= best_idx_next;
        best_diff_reg     <= best_diff_next;
        best_rgb_reg      <= best_rgb_next;
        q_rgb_reg         <= q_rgb_next;
        dist_neg_reg      <= dist_neg_next;
        dist_mag_reg      <= dist_mag_next;
        mod_reg           <= mod_next;
        code_reg          <= code_next;
        color_index_reg   <= color_index_next;
        modifier_reg      <= modifier_next;
        distance_code_reg <= distance_code_next;
    end

    assign out_valid     = out_valid_reg;
    assign color_index   = color_index_reg;
    assign modifier      = modifier_reg;
    assign distance_code = $signed(distance_code_reg);
    assign voxel_word    = {distance_code_reg, color_index_reg, modifier_reg, 2'b00};

endmodule
